// ===== hw/rtl/crcfr_pkg.sv =====
`default_nettype none

package crcfr_pkg;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [7:0]  SYNC_FIRST = 8'h55;
    localparam logic [7:0]  SYNC_SECOND = 8'hAA;
    localparam logic [7:0]  WAKE_FILL  = 8'hFF;
    localparam logic [7:0]  WAKE_MARK  = 8'h88;
    localparam logic [3:0]  ACK_LEN    = 4'd11;
    localparam logic [2:0]  WAKE_LAST  = 3'd6;

    typedef enum logic [2:0] {
        EV_CONSUMED  = 3'd0,
        EV_PAYLOAD   = 3'd1,
        EV_GOOD      = 3'd2,
        EV_CRC_ERROR = 3'd3,
        EV_ACK       = 3'd4,
        EV_WAKE      = 3'd5,
        EV_REJECT    = 3'd6
    } t_event;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

    // wake sequence ff ff ff 88 ff ff ff
    function automatic logic [7:0] wake_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd3: c = WAKE_MARK;
            3'd7: c = 8'h00;
            default: c = WAKE_FILL;
        endcase
        return c;
    endfunction

    // success text {"error":0}
    function automatic logic [7:0] ack_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:  c = 8'h7B;
            4'd1:  c = 8'h22;
            4'd2:  c = 8'h65;
            4'd3:  c = 8'h72;
            4'd4:  c = 8'h72;
            4'd5:  c = 8'h6F;
            4'd6:  c = 8'h72;
            4'd7:  c = 8'h22;
            4'd8:  c = 8'h3A;
            4'd9:  c = 8'h30;
            4'd10: c = 8'h7D;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/crc16_frame_receiver_top.sv =====
// Byte-stream receiver for a display link. Each accepted input byte yields
// exactly one result: an event code (consumed, payload byte, frame good, crc
// error, success ack, wake, rejected) with the frame's type, length, received
// and computed CRC-16/MODBUS. Frames are 55 AA, type, little-endian length,
// payload, little-endian crc; the wake sequence is FF FF FF 88 FF FF FF. A
// byte that breaks the pattern is rejected and parsing restarts. The block
// takes one byte per clock cycle while the output is not stalled, and its
// result is written to the output register in the cycle after the byte is
// accepted. The one-byte crc update and the position compare sit between
// the parser state and the result register. The input may keep flowing
// while a result waits, as long as the output register is being drained.
`default_nettype none

module crc16_frame_receiver_top
    import crcfr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_event_res,
    output logic [7:0]       o_payload_byte,
    output logic [7:0]       o_frame_type,
    output logic [15:0]      o_frame_length,
    output logic [15:0]      o_crc_received,
    output logic [15:0]      o_crc_computed
);

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_WAKE  = 2'd1,
        MODE_FRAME = 2'd2
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [16:0] r_pos, n_pos;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_len, n_len;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_lo, n_crc_lo;
    logic        r_ack, n_ack;

    logic        r_out_valid;
    t_event      r_ev, n_ev;
    logic [7:0]  r_pay, n_pay;
    logic [7:0]  r_otype, n_otype;
    logic [15:0] r_olen, n_olen;
    logic [15:0] r_crc_rx, n_crc_rx;
    logic [15:0] r_crc_calc, n_crc_calc;

    logic        w_take;
    logic        w_restart;
    logic        w_zero;
    logic [15:0] w_crc_next;
    logic [16:0] w_pay_end;
    logic [16:0] w_idx;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_take     = i_in_valid && !o_in_stall;

    assign w_crc_next = crc16_byte(r_crc, i_rx_byte);
    assign w_pay_end  = {1'b0, r_len} + 17'd5;
    assign w_idx      = r_pos - 17'd5;

    always_comb begin
        n_mode    = r_mode;
        n_pos     = r_pos;
        n_type    = r_type;
        n_len     = r_len;
        n_crc     = r_crc;
        n_crc_lo  = r_crc_lo;
        n_ack     = r_ack;
        n_ev      = EV_CONSUMED;
        n_pay     = 8'h00;
        n_crc_rx  = 16'h0000;
        w_restart = 1'b0;
        w_zero    = 1'b0;

        case (r_mode)
            MODE_WAKE: begin
                if (r_pos > 17'd6 || i_rx_byte != wake_char(r_pos[2:0])) begin
                    n_ev      = EV_REJECT;
                    w_restart = 1'b1;
                    w_zero    = 1'b1;
                end else if (r_pos[2:0] == WAKE_LAST) begin
                    n_ev      = EV_WAKE;
                    w_restart = 1'b1;
                    w_zero    = 1'b1;
                end else begin
                    n_pos = r_pos + 17'd1;
                end
            end
            MODE_FRAME: begin
                if (r_pos == 17'd1) begin
                    if (i_rx_byte != SYNC_SECOND) begin
                        n_ev      = EV_REJECT;
                        w_restart = 1'b1;
                        w_zero    = 1'b1;
                    end else begin
                        n_crc = w_crc_next;
                    end
                end else if (r_pos == 17'd2) begin
                    n_type = i_rx_byte;
                    n_crc  = w_crc_next;
                end else if (r_pos == 17'd3) begin
                    n_len = {8'h00, i_rx_byte};
                    n_crc = w_crc_next;
                end else if (r_pos == 17'd4) begin
                    n_len = {i_rx_byte, r_len[7:0]};
                    n_crc = w_crc_next;
                end else if (r_pos < w_pay_end) begin
                    if (w_idx >= {13'd0, ACK_LEN} || i_rx_byte != ack_char(w_idx[3:0])) begin
                        n_ack = 1'b0;
                    end
                    n_crc = w_crc_next;
                    n_ev  = EV_PAYLOAD;
                    n_pay = i_rx_byte;
                end else if (r_pos == w_pay_end) begin
                    n_crc_lo = i_rx_byte;
                end else begin
                    n_crc_rx  = {i_rx_byte, r_crc_lo};
                    w_restart = 1'b1;
                    if (n_crc_rx != r_crc) begin
                        n_ev = EV_CRC_ERROR;
                    end else if (r_ack && r_len == {12'd0, ACK_LEN}) begin
                        n_ev = EV_ACK;
                    end else begin
                        n_ev = EV_GOOD;
                    end
                end
                if (!w_restart) begin
                    n_pos = r_pos + 17'd1;
                end
            end
            default: begin
                if (i_rx_byte == SYNC_FIRST) begin
                    n_mode = MODE_FRAME;
                    n_pos  = 17'd1;
                    n_crc  = crc16_byte(CRC_INIT, i_rx_byte);
                end else if (i_rx_byte == WAKE_FILL) begin
                    n_mode = MODE_WAKE;
                    n_pos  = 17'd1;
                end else begin
                    n_ev      = EV_REJECT;
                    w_restart = 1'b1;
                    w_zero    = 1'b1;
                end
            end
        endcase

        if (w_zero) begin
            n_otype    = 8'h00;
            n_olen     = 16'h0000;
            n_crc_calc = 16'h0000;
        end else begin
            n_otype    = n_type;
            n_olen     = n_len;
            n_crc_calc = n_crc;
        end

        if (w_restart) begin
            n_mode   = MODE_IDLE;
            n_pos    = 17'd0;
            n_type   = 8'h00;
            n_len    = 16'h0000;
            n_crc    = CRC_INIT;
            n_crc_lo = 8'h00;
            n_ack    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_pos       <= 17'd0;
            r_type      <= 8'h00;
            r_len       <= 16'h0000;
            r_crc       <= CRC_INIT;
            r_crc_lo    <= 8'h00;
            r_ack       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_mode      <= n_mode;
                r_pos       <= n_pos;
                r_type      <= n_type;
                r_len       <= n_len;
                r_crc       <= n_crc;
                r_crc_lo    <= n_crc_lo;
                r_ack       <= n_ack;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_ev       <= n_ev;
            r_pay      <= n_pay;
            r_otype    <= n_otype;
            r_olen     <= n_olen;
            r_crc_rx   <= n_crc_rx;
            r_crc_calc <= n_crc_calc;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_res    = r_ev;
    assign o_payload_byte = r_pay;
    assign o_frame_type   = r_otype;
    assign o_frame_length = r_olen;
    assign o_crc_received = r_crc_rx;
    assign o_crc_computed = r_crc_calc;

endmodule

`default_nettype wire

// ===== hw/rtl/crcfr_checker.sv =====
`default_nettype none

module crcfr_checker
    import crcfr_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [2:0]  o_event_res,
    input wire logic [7:0]  o_payload_byte,
    input wire logic [7:0]  o_frame_type,
    input wire logic [15:0] o_frame_length,
    input wire logic [15:0] o_crc_received,
    input wire logic [15:0] o_crc_computed
);

    // input stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // an accepted byte always yields a result next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted byte produced no result");

    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_res != EV_PAYLOAD) |-> (o_payload_byte == 8'h00))
        else $error("payload byte set outside a payload transfer");

    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_res == EV_WAKE || o_event_res == EV_REJECT))
        |-> (o_frame_type == 8'h00 && o_frame_length == 16'h0000 &&
             o_crc_received == 16'h0000 && o_crc_computed == 16'h0000))
        else $error("frame fields not cleared on wake or reject");

    a_crc_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_res == EV_GOOD || o_event_res == EV_ACK ||
                         o_event_res == EV_CRC_ERROR))
        |-> ((o_crc_received == o_crc_computed) == (o_event_res != EV_CRC_ERROR)))
        else $error("frame verdict disagrees with crc values");

endmodule

bind crc16_frame_receiver_top crcfr_checker u_crcfr_checker (.*);

`default_nettype wire
